/* rtl/cau_pkg.sv */
package cau_pkg;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_EQ  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  localparam int unsigned QBITS = 32;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } pack_t;

  // everything that rides along the divider next to the quotients
  typedef struct packed {
    logic        div_en;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        eq;
    logic [1:0]  status;
    logic        neg_re;
    logic        neg_im;
  } side_t;

  function automatic logic [63:0] mag65(logic signed [64:0] x);
    logic [64:0] t;
    t = x[64] ? (~x + 65'd1) : x;
    return t[63:0];
  endfunction

  // saturate sign and magnitude to a 32-bit two's complement pattern
  function automatic pack_t sat_pack(logic [63:0] m, logic neg);
    pack_t       p;
    logic [63:0] t;
    p.sat = 1'b0;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) begin
        p.val = 32'h8000_0000;
        p.sat = 1'b1;
      end else begin
        t     = ~m + 64'd1;
        p.val = t[31:0];
      end
    end else begin
      if (m > 64'h0000_0000_7fff_ffff) begin
        p.val = 32'h7fff_ffff;
        p.sat = 1'b1;
      end else begin
        p.val = m[31:0];
      end
    end
    return p;
  endfunction

endpackage

/* rtl/cau_in_if.sv */
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

/* rtl/cau_out_if.sv */
interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic               is_equal;
  logic [1:0]         status;

  modport source (output valid, res_re, res_im, is_equal, status, input ready);
  modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

/* rtl/cau_div.sv */
module cau_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         num_re_i,
  input  logic [63:0]         num_im_i,
  input  logic [63:0]         den_i,
  input  cau_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [31:0]         q_re_o,
  output logic [31:0]         q_im_o,
  output logic                ovf_re_o,
  output logic                ovf_im_o,
  output cau_pkg::side_t      side_o
);

  localparam int unsigned NS = cau_pkg::QBITS;
  localparam int unsigned SH = cau_pkg::QBITS - FRAC_BITS;

  logic [63:0]    rem_q [2][NS+1];
  logic [NS-1:0]  lo_q  [2][NS+1];
  logic [NS-1:0]  quo_q [2][NS+1];
  logic           ovf_q [2][NS+1];
  logic [63:0]    den_q [NS+1];
  logic           valid_q [NS+1];
  cau_pkg::side_t side_q [NS+1];

  logic [63:0] num [2];
  logic [63:0] hi  [2];
  logic [63:0] shl [2];

  assign num[0] = num_re_i;
  assign num[1] = num_im_i;

  // quotient fits 32 bits only when the upper dividend bits stay below den
  for (genvar p = 0; p < 2; p++) begin : g_prep
    assign hi[p]  = num[p] >> SH;
    assign shl[p] = num[p] << FRAC_BITS;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[p][0] <= hi[p];
        lo_q[p][0]  <= shl[p][NS-1:0];
        quo_q[p][0] <= '0;
        ovf_q[p][0] <= (hi[p] >= den_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= NS; k++) begin : g_step
    for (genvar p = 0; p < 2; p++) begin : g_part
      logic [64:0] r2;
      logic [64:0] diff;
      logic        ge;

      assign r2   = {rem_q[p][k-1], lo_q[p][k-1][NS-1]};
      assign ge   = (r2 >= {1'b0, den_q[k-1]});
      assign diff = r2 - {1'b0, den_q[k-1]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[p][k] <= ge ? diff[63:0] : r2[63:0];
          lo_q[p][k]  <= {lo_q[p][k-1][NS-2:0], 1'b0};
          quo_q[p][k] <= {quo_q[p][k-1][NS-2:0], ge};
          ovf_q[p][k] <= ovf_q[p][k-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign valid_o  = valid_q[NS];
  assign q_re_o   = quo_q[0][NS];
  assign q_im_o   = quo_q[1][NS];
  assign ovf_re_o = ovf_q[0][NS];
  assign ovf_im_o = ovf_q[1][NS];
  assign side_o   = side_q[NS];

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit: add, subtract, multiply, divide or compare two complex
// operands in signed fixed point with FRAC_BITS fraction bits. It takes one
// transaction per clock while the output is not stalled. From acceptance, each result
// passes the operand, product and sum registers, the pipelined restoring divider
// that yields one quotient bit per stage, and then the output register.
// Every mode runs through the same pipeline, so results leave in order. A stalled
// output freezes the whole pipeline and deasserts in_i.ready.
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  cau_in_if.sink          in_i,
  cau_out_if.source       out_o
);

  logic en;

  // stage 1: operands
  logic               s1_valid_q;
  logic [2:0]         s1_mode_q;
  logic signed [31:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  // stage 2: products and sums
  logic               s2_valid_q;
  logic [2:0]         s2_mode_q;
  logic signed [63:0] s2_p_rr_q, s2_p_ii_q, s2_p_ri_q, s2_p_ir_q, s2_sq_r_q, s2_sq_i_q;
  logic signed [32:0] s2_sr_q, s2_si_q;
  logic               s2_eq_q;
  logic signed [32:0] s2_sr_d, s2_si_d;

  // stage 3: wide sums
  logic               s3_valid_q;
  logic [2:0]         s3_mode_q;
  logic signed [64:0] s3_tr_q, s3_ti_q, s3_nr_q, s3_ni_q;
  logic [63:0]        s3_den_q;
  cau_pkg::pack_t     s3_add_re_q, s3_add_im_q;
  logic               s3_eq_q;

  // stage 4 feed
  logic [63:0]    mul_re_m, mul_im_m;
  cau_pkg::pack_t mul_re_p, mul_im_p;
  cau_pkg::side_t side_d;

  // divider output
  logic           dv_valid;
  logic [31:0]    dv_q_re, dv_q_im;
  logic           dv_ovf_re, dv_ovf_im;
  cau_pkg::side_t dv_side;
  logic [63:0]    q_re_ext, q_im_ext;
  cau_pkg::pack_t div_re_p, div_im_p;

  // output register
  logic               out_valid_q;
  logic signed [31:0] out_re_q, out_re_d, out_im_q, out_im_d;
  logic               out_eq_q;
  logic [1:0]         out_st_q, out_st_d;

  assign en         = ~out_valid_q | out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mode_q <= in_i.mode;
      s1_ar_q   <= in_i.a_re;
      s1_ai_q   <= in_i.a_im;
      s1_br_q   <= in_i.b_re;
      s1_bi_q   <= in_i.b_im;
    end
  end

  always_comb begin
    if (s1_mode_q == cau_pkg::MODE_SUB) begin
      s2_sr_d = 33'(s1_ar_q) - 33'(s1_br_q);
      s2_si_d = 33'(s1_ai_q) - 33'(s1_bi_q);
    end else begin
      s2_sr_d = 33'(s1_ar_q) + 33'(s1_br_q);
      s2_si_d = 33'(s1_ai_q) + 33'(s1_bi_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_mode_q <= s1_mode_q;
      s2_p_rr_q <= 64'(s1_ar_q) * 64'(s1_br_q);
      s2_p_ii_q <= 64'(s1_ai_q) * 64'(s1_bi_q);
      s2_p_ri_q <= 64'(s1_ar_q) * 64'(s1_bi_q);
      s2_p_ir_q <= 64'(s1_ai_q) * 64'(s1_br_q);
      s2_sq_r_q <= 64'(s1_br_q) * 64'(s1_br_q);
      s2_sq_i_q <= 64'(s1_bi_q) * 64'(s1_bi_q);
      s2_sr_q   <= s2_sr_d;
      s2_si_q   <= s2_si_d;
      s2_eq_q   <= (s1_ar_q == s1_br_q) && (s1_ai_q == s1_bi_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_mode_q   <= s2_mode_q;
      s3_tr_q     <= 65'(s2_p_rr_q) - 65'(s2_p_ii_q);
      s3_ti_q     <= 65'(s2_p_ri_q) + 65'(s2_p_ir_q);
      s3_nr_q     <= 65'(s2_p_rr_q) + 65'(s2_p_ii_q);
      s3_ni_q     <= 65'(s2_p_ir_q) - 65'(s2_p_ri_q);
      s3_den_q    <= 64'(s2_sq_r_q) + 64'(s2_sq_i_q);
      s3_add_re_q <= cau_pkg::sat_pack(cau_pkg::mag65(65'(s2_sr_q)), s2_sr_q[32]);
      s3_add_im_q <= cau_pkg::sat_pack(cau_pkg::mag65(65'(s2_si_q)), s2_si_q[32]);
      s3_eq_q     <= s2_eq_q;
    end
  end

  assign mul_re_m = cau_pkg::mag65(s3_tr_q) >> FRAC_BITS;
  assign mul_im_m = cau_pkg::mag65(s3_ti_q) >> FRAC_BITS;
  assign mul_re_p = cau_pkg::sat_pack(mul_re_m, s3_tr_q[64] && (mul_re_m != '0));
  assign mul_im_p = cau_pkg::sat_pack(mul_im_m, s3_ti_q[64] && (mul_im_m != '0));

  always_comb begin
    side_d        = '0;
    side_d.neg_re = s3_nr_q[64];
    side_d.neg_im = s3_ni_q[64];
    unique case (s3_mode_q)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        side_d.res_re = s3_add_re_q.val;
        side_d.res_im = s3_add_im_q.val;
        side_d.status = (s3_add_re_q.sat | s3_add_im_q.sat) ? cau_pkg::ST_SAT
                                                            : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_MUL: begin
        side_d.res_re = mul_re_p.val;
        side_d.res_im = mul_im_p.val;
        side_d.status = (mul_re_p.sat | mul_im_p.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_DIV: begin
        if (s3_den_q == '0) begin
          side_d.status = cau_pkg::ST_DIV0;
        end else begin
          side_d.div_en = 1'b1;
        end
      end
      cau_pkg::MODE_EQ: begin
        side_d.eq = s3_eq_q;
      end
      default: begin
        side_d.status = cau_pkg::ST_OK;
      end
    endcase
  end

  cau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s3_valid_q),
    .num_re_i (cau_pkg::mag65(s3_nr_q)),
    .num_im_i (cau_pkg::mag65(s3_ni_q)),
    .den_i    (s3_den_q),
    .side_i   (side_d),
    .valid_o  (dv_valid),
    .q_re_o   (dv_q_re),
    .q_im_o   (dv_q_im),
    .ovf_re_o (dv_ovf_re),
    .ovf_im_o (dv_ovf_im),
    .side_o   (dv_side)
  );

  assign q_re_ext = dv_ovf_re ? 64'h0000_0001_0000_0000 : {32'd0, dv_q_re};
  assign q_im_ext = dv_ovf_im ? 64'h0000_0001_0000_0000 : {32'd0, dv_q_im};
  assign div_re_p = cau_pkg::sat_pack(q_re_ext, dv_side.neg_re && (q_re_ext != '0));
  assign div_im_p = cau_pkg::sat_pack(q_im_ext, dv_side.neg_im && (q_im_ext != '0));

  always_comb begin
    if (dv_side.div_en) begin
      out_re_d = div_re_p.val;
      out_im_d = div_im_p.val;
      out_st_d = (div_re_p.sat | div_im_p.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      out_re_d = dv_side.res_re;
      out_im_d = dv_side.res_im;
      out_st_d = dv_side.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_re_q <= out_re_d;
      out_im_q <= out_im_d;
      out_eq_q <= dv_side.eq;
      out_st_q <= out_st_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.res_re   = out_re_q;
  assign out_o.res_im   = out_im_q;
  assign out_o.is_equal = out_eq_q;
  assign out_o.status   = out_st_q;

endmodule

/* rtl/cau_chk.sv */
module cau_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] res_re_i,
  input logic [31:0] res_im_i,
  input logic        is_equal_i,
  input logic [1:0]  status_i
);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_re_i) && $stable(res_im_i)
      && $stable(status_i) && $stable(is_equal_i))
    else $error("stalled result changed");

  // empty output never blocks input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  a_div0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == cau_pkg::ST_DIV0 |->
      res_re_i == '0 && res_im_i == '0 && !is_equal_i)
    else $error("division by zero with nonzero result");

  a_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_equal_i |->
      status_i == cau_pkg::ST_OK && res_re_i == '0 && res_im_i == '0)
    else $error("equality result with parts or status");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i != 2'd3)
    else $error("undefined status code");

endmodule

bind complex_arithmetic_unit cau_chk u_cau_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .res_re_i    (out_o.res_re),
  .res_im_i    (out_o.res_im),
  .is_equal_i  (out_o.is_equal),
  .status_i    (out_o.status)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FRAC = 16;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } operands_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  status;
  } answer_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cau_in_if  in_if ();
  cau_out_if out_if ();

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk_i = ~clk_i;

  answer_t     pending_answers[$];
  int          errors       = 0;
  int          checked      = 0;
  int          sent         = 0;
  int          quiet_cycles = 0;
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int          mode_count[8];

  initial begin
    in_if.valid   = 1'b0;
    in_if.mode    = '0;
    in_if.a_re    = '0;
    in_if.a_im    = '0;
    in_if.b_re    = '0;
    in_if.b_im    = '0;
    out_if.ready  = 1'b0;
  end

  function automatic logic [31:0] clamp(input logic signed [97:0] v, inout logic sat);
    if (v > 98'sh7fff_ffff) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -98'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] scale_down(input logic signed [65:0] v, inout logic sat);
    logic signed [65:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> FRAC;
    if (v < 0) m = -m;
    return clamp(98'(m), sat);
  endfunction

  function automatic logic [31:0] quotient(input logic signed [65:0] num,
                                           input logic [95:0] den, inout logic sat);
    logic signed [65:0] m;
    logic [95:0]        q;
    logic signed [97:0] v;
    m = (num < 0) ? -num : num;
    q = (96'(m[64:0]) << FRAC) / den;
    v = {2'b00, q};
    if (num < 0) v = -v;
    return clamp(v, sat);
  endfunction

  function automatic answer_t compute_answer(input operands_t x);
    answer_t            r;
    logic signed [65:0] ar, ai, br, bi, sr, si;
    logic [95:0]        den;
    logic               sat;
    ar  = 66'(x.a_re);
    ai  = 66'(x.a_im);
    br  = 66'(x.b_re);
    bi  = 66'(x.b_im);
    r   = '{re: '0, im: '0, eq: 1'b0, status: cau_pkg::ST_OK};
    sat = 1'b0;
    case (x.mode)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        sr   = (x.mode == cau_pkg::MODE_SUB) ? ar - br : ar + br;
        si   = (x.mode == cau_pkg::MODE_SUB) ? ai - bi : ai + bi;
        r.re = clamp(98'(sr), sat);
        r.im = clamp(98'(si), sat);
        r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_MUL: begin
        r.re = scale_down(ar * br - ai * bi, sat);
        r.im = scale_down(ar * bi + ai * br, sat);
        r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_DIV: begin
        sr  = br * br + bi * bi;
        den = 96'(sr[64:0]);
        if (den == 0) begin
          r.status = cau_pkg::ST_DIV0;
        end else begin
          r.re = quotient(ar * br + ai * bi, den, sat);
          r.im = quotient(ai * br - ar * bi, den, sat);
          r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::MODE_EQ: begin
        r.eq = (x.a_re == x.b_re) && (x.a_im == x.b_im);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_op(input operands_t x);
    if ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= x.mode;
    in_if.a_re  <= x.a_re;
    in_if.a_im  <= x.a_im;
    in_if.b_re  <= x.b_re;
    in_if.b_im  <= x.b_im;
    do @(posedge clk_i); while (!in_if.ready);
    pending_answers.push_back(compute_answer(x));
    mode_count[x.mode]++;
    sent++;
  endtask

  task automatic send(input logic [2:0] m, input logic [31:0] a, input logic [31:0] b,
                      input logic [31:0] c, input logic [31:0] d);
    operands_t x;
    x = '{mode: m, a_re: a, a_im: b, b_re: c, b_im: d};
    send_op(x);
  endtask

  function automatic logic [31:0] random_part();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff - $urandom_range(2);
      1:       return 32'h8000_0000 + $urandom_range(2);
      2:       return 32'($signed($urandom_range(8)) - 4);
      3, 4:    return 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
      5, 6:    return 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result re=%h im=%h eq=%b st=%0d", $time,
                 out_if.res_re, out_if.res_im, out_if.is_equal, out_if.status);
      end else begin
        e = pending_answers.pop_front();
        checked++;
        if (out_if.res_re !== e.re || out_if.res_im !== e.im ||
            out_if.is_equal !== e.eq || out_if.status !== e.status) begin
          errors++;
          $display("%0t: mismatch expected re=%h im=%h eq=%b st=%0d actual re=%h im=%h eq=%b st=%0d",
                   $time, e.re, e.im, e.eq, e.status, out_if.res_re, out_if.res_im,
                   out_if.is_equal, out_if.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (!in_if.valid && pending_answers.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_answers.size());
      $display("complex_arithmetic_unit test failed");
      $finish;
    end
  end

  task automatic test_add_sub();
    send(cau_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send(cau_pkg::MODE_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(cau_pkg::MODE_ADD, 32'h0001_8000, 32'hfffe_0000, 32'h0000_8000, 32'h0002_0000);
    send(cau_pkg::MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send(cau_pkg::MODE_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send(cau_pkg::MODE_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
  endtask

  task automatic test_mul();
    send(cau_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(cau_pkg::MODE_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send(cau_pkg::MODE_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000);
    send(cau_pkg::MODE_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send(cau_pkg::MODE_MUL, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000);
  endtask

  task automatic test_div();
    send(cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send(cau_pkg::MODE_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
    send(cau_pkg::MODE_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send(cau_pkg::MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send(cau_pkg::MODE_DIV, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);
    send(cau_pkg::MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send(cau_pkg::MODE_DIV, 32'hffff_0000, 32'h0001_0000, 32'h0003_0000, 32'h0000_0000);
  endtask

  task automatic test_compare_and_unused();
    send(cau_pkg::MODE_EQ, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(cau_pkg::MODE_EQ, 32'h1234_5678, 32'h0000_0000, 32'h1234_5678, 32'h0000_0001);
    send(cau_pkg::MODE_EQ, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send(3'd5, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(3'd6, 32'h8000_0000, 32'h1, 32'h0, 32'h0);
    send(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(input int n, input int in_pct, input int out_pct);
    operands_t x;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (n) begin
      x.mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      x.a_re = random_part();
      x.a_im = random_part();
      x.b_re = random_part();
      x.b_im = random_part();
      if (x.mode == cau_pkg::MODE_EQ && $urandom_range(1)) begin
        x.b_re = x.a_re;
        if ($urandom_range(1)) x.b_im = x.a_im;
      end
      if (x.mode == cau_pkg::MODE_DIV && $urandom_range(15) == 0) begin
        x.b_re = '0;
        x.b_im = '0;
      end
      send_op(x);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_sub();
    test_mul();
    test_div();
    test_compare_and_unused();
    test_random(510, 35, 74);
    test_random(510, 74, 35);
    test_random(510, 0, 0);
    in_if.valid <= 1'b0;
    out_idle_pct = 0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("sent %0d transactions, checked %0d results", sent, checked);
    $display("per mode add/sub/mul/div/eq/unused: %0d/%0d/%0d/%0d/%0d/%0d", mode_count[0],
             mode_count[1], mode_count[2], mode_count[3], mode_count[4],
             mode_count[5] + mode_count[6] + mode_count[7]);
    if (errors == 0 && pending_answers.size() == 0)
      $display("complex_arithmetic_unit test passed");
    else
      $display("complex_arithmetic_unit test failed");
    $finish;
  end

endmodule

/* files.f */
rtl/cau_pkg.sv
rtl/cau_in_if.sv
rtl/cau_out_if.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_chk.sv
tb/sv/testbench.sv
